FILE: hw/rtl/cll_pkg.sv
// request and result types and codes for the circular list with cursor
`timescale 1ns / 1ps

package cll_pkg;

    typedef enum logic [1:0] {
        OP_ADD     = 2'd0,
        OP_REMOVE  = 2'd1,
        OP_ADVANCE = 2'd2,
        OP_QUERY   = 2'd3
    } op_t;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        op_t                op;
        logic signed [31:0] item_value;
    } req_t;

    typedef struct packed {
        logic signed [31:0] cursor_value;
        logic signed [31:0] following_value;
        logic               is_empty;
        logic        [4:0]  node_count;
        logic        [1:0]  status;
    } rsp_t;

endpackage

FILE: hw/rtl/cll_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module cll_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hw/rtl/circular_list_with_cursor.sv
// top level of the bounded circular linked list with cursor
`timescale 1ns / 1ps

// usage:
// a request (op, item_value) is taken at a clock edge with start high and busy low.
// each request gives exactly one result on result, marked by done for one cycle;
// the receiver cannot hold results off.
// done is set at the accepting edge itself for: query, refused ops, removing
// the only node, add to an empty list; add to a non-empty list goes through
// S_TAIL (second link write to the tail node); remove and advance go through
// S_LINK, then S_VAL (link read, then dependent value read).
// busy is high while in S_TAIL, S_LINK or S_VAL, so a new request may be given
// in the cycle done is shown; a request is not taken while an earlier one is
// in progress, since the link and value memories have a single write port
// and the value read depends on the link read.
// the lowest free node is picked by a priority encoder on the free map.
// reset empties the list and marks every node free; memory contents are not
// cleared, since only nodes in the ring are ever read.

module circular_list_with_cursor #(
    parameter int CAPACITY = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  cll_pkg::req_t request,
    output logic          done,
    output cll_pkg::rsp_t result
);

    localparam int PTR_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_TAIL = 4'b0010,
        S_LINK = 4'b0100,
        S_VAL  = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [PTR_W-1:0]    cursor_reg, cursor_next;
    logic [PTR_W-1:0]    tail_reg, tail_next;
    logic [PTR_W-1:0]    cur_next_reg, cur_next_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CAPACITY-1:0] free_reg, free_next;
    logic                rm_reg, rm_next;
    logic                done_reg;
    logic signed [31:0]  cur_val_reg, cur_val_next;
    logic signed [31:0]  fol_val_reg, fol_val_next;
    cll_pkg::rsp_t       result_reg, result_next;

    logic                accept;
    logic                emit;
    logic [1:0]          status_v;
    logic                count_zero;
    logic                count_full;
    logic [PTR_W-1:0]    alloc;

    logic                link_we, link_re;
    logic [PTR_W-1:0]    link_waddr, link_wdata, link_raddr, link_rdata;
    logic                val_we, val_re;
    logic [PTR_W-1:0]    val_waddr, val_raddr;
    logic [31:0]         val_wdata, val_rdata;

    cll_ram #(
        .WIDTH (PTR_W),
        .DEPTH (CAPACITY)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .re    (link_re),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    cll_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_value_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (val_wdata),
        .re    (val_re),
        .raddr (val_raddr),
        .rdata (val_rdata)
    );

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && (state_reg == S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    assign count_zero = (count_reg == '0);
    assign count_full = (count_reg == CNT_W'(CAPACITY));

    // lowest free node
    always_comb
    begin
        alloc = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (free_reg[i])
            begin
                alloc = PTR_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cursor_next   = cursor_reg;
        tail_next     = tail_reg;
        cur_next_next = cur_next_reg;
        count_next    = count_reg;
        free_next     = free_reg;
        rm_next       = rm_reg;
        cur_val_next  = cur_val_reg;
        fol_val_next  = fol_val_reg;
        status_v      = cll_pkg::STATUS_OK;
        emit          = 1'b0;
        link_we       = 1'b0;
        link_waddr    = cursor_reg;
        link_wdata    = cursor_reg;
        link_re       = 1'b0;
        link_raddr    = cur_next_reg;
        val_we        = 1'b0;
        val_waddr     = alloc;
        val_wdata     = request.item_value;
        val_re        = 1'b0;
        val_raddr     = link_rdata;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (request.op)
                        cll_pkg::OP_ADD:
                        begin
                            if (count_full)
                            begin
                                status_v = cll_pkg::STATUS_FULL;
                                emit     = 1'b1;
                            end
                            else
                            begin
                                val_we           = 1'b1;
                                link_we          = 1'b1;
                                link_waddr       = alloc;
                                link_wdata       = count_zero ? alloc : cursor_reg;
                                free_next[alloc] = 1'b0;
                                count_next       = count_reg + CNT_W'(1);
                                cursor_next      = alloc;
                                cur_val_next     = request.item_value;
                                if (count_zero)
                                begin
                                    tail_next     = alloc;
                                    cur_next_next = alloc;
                                    fol_val_next  = request.item_value;
                                    emit          = 1'b1;
                                end
                                else
                                begin
                                    cur_next_next = cursor_reg;
                                    fol_val_next  = cur_val_reg;
                                    state_next    = S_TAIL;
                                end
                            end
                        end
                        cll_pkg::OP_REMOVE:
                        begin
                            if (count_zero)
                            begin
                                status_v = cll_pkg::STATUS_EMPTY;
                                emit     = 1'b1;
                            end
                            else if (cur_next_reg == cursor_reg)
                            begin
                                free_next[cur_next_reg] = 1'b1;
                                count_next              = '0;
                                emit                    = 1'b1;
                            end
                            else
                            begin
                                free_next[cur_next_reg] = 1'b1;
                                count_next              = count_reg - CNT_W'(1);
                                if (cur_next_reg == tail_reg)
                                begin
                                    tail_next = cursor_reg;
                                end
                                link_re    = 1'b1;
                                rm_next    = 1'b1;
                                state_next = S_LINK;
                            end
                        end
                        cll_pkg::OP_ADVANCE:
                        begin
                            if (count_zero)
                            begin
                                status_v = cll_pkg::STATUS_EMPTY;
                                emit     = 1'b1;
                            end
                            else
                            begin
                                tail_next    = cursor_reg;
                                cursor_next  = cur_next_reg;
                                cur_val_next = fol_val_reg;
                                link_re      = 1'b1;
                                rm_next      = 1'b0;
                                state_next   = S_LINK;
                            end
                        end
                        cll_pkg::OP_QUERY:
                        begin
                            emit = 1'b1;
                        end
                        default:
                        begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            S_TAIL:
            begin
                // tail now links to the new cursor
                link_we    = 1'b1;
                link_waddr = tail_reg;
                link_wdata = cursor_reg;
                emit       = 1'b1;
                state_next = S_IDLE;
            end
            S_LINK:
            begin
                cur_next_next = link_rdata;
                if (rm_reg)
                begin
                    link_we    = 1'b1;
                    link_waddr = cursor_reg;
                    link_wdata = link_rdata;
                end
                val_re     = 1'b1;
                state_next = S_VAL;
            end
            S_VAL:
            begin
                fol_val_next = val_rdata;
                emit         = 1'b1;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        result_next.cursor_value    = (count_next == '0) ? '0 : cur_val_next;
        result_next.following_value = (count_next == '0) ? '0 : fol_val_next;
        result_next.is_empty        = (count_next == '0);
        result_next.node_count      = 5'(count_next);
        result_next.status          = status_v;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cursor_reg <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
            free_reg   <= '1;
            rm_reg     <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cursor_reg <= cursor_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            free_reg   <= free_next;
            rm_reg     <= rm_next;
            done_reg   <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_next_reg <= cur_next_next;
        cur_val_reg  <= cur_val_next;
        fol_val_reg  <= fol_val_next;
        if (emit)
        begin
            result_reg <= result_next;
        end
    end

    // every node is either in the ring or free
    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |-> ($countones(free_reg) + int'(count_reg) == CAPACITY))
        else $error("free map and node count disagree");

    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |-> (count_reg <= CNT_W'(CAPACITY)))
        else $error("node count above capacity");

    // an accepted request reports next cycle or is still in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (done || busy))
        else $error("request dropped");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.is_empty == (count_reg == '0)))
        else $error("empty flag disagrees with node count");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LINK || state_reg == S_TAIL) |-> (count_reg != '0))
        else $error("list walk on an empty list");

endmodule

FILE: verif/tb_top.sv
// self-checking testbench for the circular list with cursor: random and directed requests
`timescale 1ns / 1ps

module tb_top;

    localparam int CAPACITY    = 16;
    localparam int RANDOM_OPS  = 850;
    localparam int QUIET_TAIL  = 150;
    localparam int CYCLE_LIMIT = 200000;

    class list_scoreboard;
        logic signed [31:0]     node_val [CAPACITY];
        logic [3:0]             node_link [CAPACITY];
        logic [CAPACITY-1:0]    free_nodes;
        logic [3:0]             cursor;
        logic [3:0]             tail;
        int unsigned            count;
        cll_pkg::rsp_t          expected_views [$];
        int unsigned            errors;

        function new();
            free_nodes = '1;
            cursor     = '0;
            tail       = '0;
            count      = 0;
            errors     = 0;
        endfunction

        function void note_request(cll_pkg::req_t r);
            cll_pkg::rsp_t view;
            logic [3:0]    slot;
            logic [3:0]    gone;
            bit            found;
            view = '0;
            view.status = cll_pkg::STATUS_OK;
            case (r.op)
                cll_pkg::OP_ADD:
                begin
                    if (count >= CAPACITY)
                    begin
                        view.status = cll_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        found = 1'b0;
                        slot  = '0;
                        for (int i = 0; i < CAPACITY; i++)
                        begin
                            if (!found && free_nodes[i])
                            begin
                                slot  = i[3:0];
                                found = 1'b1;
                            end
                        end
                        free_nodes[slot] = 1'b0;
                        node_val[slot] = r.item_value;
                        if (count == 0)
                        begin
                            node_link[slot] = slot;
                            tail = slot;
                        end
                        else
                        begin
                            node_link[slot] = cursor;
                            node_link[tail] = slot;
                        end
                        cursor = slot;
                        count++;
                    end
                end
                cll_pkg::OP_REMOVE:
                begin
                    if (count == 0)
                    begin
                        view.status = cll_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        gone = node_link[cursor];
                        if (gone == cursor)
                        begin
                            count = 0;
                        end
                        else
                        begin
                            node_link[cursor] = node_link[gone];
                            if (gone == tail)
                                tail = cursor;
                            count--;
                        end
                        free_nodes[gone] = 1'b1;
                    end
                end
                cll_pkg::OP_ADVANCE:
                begin
                    if (count == 0)
                    begin
                        view.status = cll_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        tail   = cursor;
                        cursor = node_link[cursor];
                    end
                end
                default:
                begin
                end
            endcase
            if (count != 0)
            begin
                view.cursor_value    = node_val[cursor];
                view.following_value = node_val[node_link[cursor]];
            end
            view.is_empty   = (count == 0);
            view.node_count = count[4:0];
            expected_views.push_back(view);
        endfunction

        function void check_result(cll_pkg::rsp_t got);
            cll_pkg::rsp_t want;
            if (expected_views.size() == 0)
            begin
                $error("result with no request pending: %p", got);
                errors++;
                return;
            end
            want = expected_views.pop_front();
            if (got.cursor_value !== want.cursor_value)
            begin
                $error("cursor_value: expected %0d, got %0d", want.cursor_value,
                       got.cursor_value);
                errors++;
            end
            if (got.following_value !== want.following_value)
            begin
                $error("following_value: expected %0d, got %0d", want.following_value,
                       got.following_value);
                errors++;
            end
            if (got.is_empty !== want.is_empty)
            begin
                $error("is_empty: expected %0d, got %0d", want.is_empty, got.is_empty);
                errors++;
            end
            if (got.node_count !== want.node_count)
            begin
                $error("node_count: expected %0d, got %0d", want.node_count, got.node_count);
                errors++;
            end
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return expected_views.size();
        endfunction
    endclass

    logic          clk = 1'b0;
    logic          rst_n;
    logic          start;
    logic          busy;
    cll_pkg::req_t request;
    logic          done;
    cll_pkg::rsp_t result;

    list_scoreboard sb = new();
    int unsigned    cycles = 0;

    circular_list_with_cursor #(
        .CAPACITY(CAPACITY)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .request(request),
        .done(done),
        .result(result)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.note_request(request);
            if (done)
                sb.check_result(result);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_request(input cll_pkg::op_t op, input logic [31:0] value,
                                input bit may_idle);
        cll_pkg::req_t r;
        r.op = op;
        r.item_value = value;
        if (may_idle && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        request <= r;
        start   <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            4: return $urandom_range(0, 255);
            default: return $urandom;
        endcase
    endfunction

    task automatic run_directed();
        send_request(cll_pkg::OP_QUERY, 32'h0, 1'b0);
        send_request(cll_pkg::OP_REMOVE, 32'h0, 1'b0);
        send_request(cll_pkg::OP_ADVANCE, 32'h0, 1'b0);
        send_request(cll_pkg::OP_ADD, 32'h8000_0000, 1'b0);
        send_request(cll_pkg::OP_ADVANCE, 32'h0, 1'b0);
        send_request(cll_pkg::OP_REMOVE, 32'h0, 1'b0);
        send_request(cll_pkg::OP_ADD, 32'h7fff_ffff, 1'b0);
        send_request(cll_pkg::OP_ADD, 32'hffff_ffff, 1'b0);
        send_request(cll_pkg::OP_REMOVE, 32'h0, 1'b0);
        send_request(cll_pkg::OP_QUERY, 32'h0, 1'b0);
        for (int i = 0; i < CAPACITY - 1; i++)
            send_request(cll_pkg::OP_ADD,
                         (i % 2) ? 32'haaaa_aaaa : 32'h5555_5555 + i, 1'b0);
        send_request(cll_pkg::OP_ADD, 32'h1234_5678, 1'b0);
    endtask

    task automatic run_random();
        int unsigned  add_pct;
        int unsigned  remove_pct;
        int unsigned  advance_pct;
        int unsigned  k;
        cll_pkg::op_t op;
        add_pct     = 40;
        remove_pct  = 30;
        advance_pct = 20;
        for (int n = 0; n < RANDOM_OPS; n++)
        begin
            if (n % 40 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:
                    begin
                        add_pct = 70; remove_pct = 10; advance_pct = 15;
                    end
                    1:
                    begin
                        add_pct = 15; remove_pct = 60; advance_pct = 15;
                    end
                    default:
                    begin
                        add_pct = 35; remove_pct = 30; advance_pct = 25;
                    end
                endcase
            end
            k = $urandom_range(0, 99);
            if (k < add_pct)
                op = cll_pkg::OP_ADD;
            else if (k < add_pct + remove_pct)
                op = cll_pkg::OP_REMOVE;
            else if (k < add_pct + remove_pct + advance_pct)
                op = cll_pkg::OP_ADVANCE;
            else
                op = cll_pkg::OP_QUERY;
            send_request(op, pick_value(), n < RANDOM_OPS - QUIET_TAIL);
        end
    endtask

    initial
    begin
        rst_n   = 1'b0;
        start   = 1'b0;
        request = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random();
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
